/* rtl/core/nan_skipping_quantile_macros.svh */
// Assertion macros used by the checker file of the quantile block.
`ifndef NAN_SKIPPING_QUANTILE_MACROS_SVH
`define NAN_SKIPPING_QUANTILE_MACROS_SVH

// Checked on every rising edge while reset is released.
`define NSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define NSQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/nsq_pkg.sv */
// Package with the shared types and constants of the quantile block.
`timescale 1ns / 1ps
`default_nettype none
package nsq_pkg;
    localparam logic [16:0] QFRAC_RESET = 17'd32768;
    localparam logic [16:0] QFRAC_ONE   = 17'd65536;
    localparam int          FRAC_BITS   = 16;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_POS,
        ST_START,
        ST_SEL,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_IDLE,
        SEL_RUN,
        SEL_UPD
    } t_sel_state;
endpackage
`default_nettype wire

/* rtl/core/nsq_store.sv */
// Row store: a single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nsq_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/nsq_select.sv */
// Bitwise radix selection of two order statistics, one memory pass per key bit.
`timescale 1ns / 1ps
`default_nettype none
module nsq_select #(
    parameter int MAX_ROW     = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [$clog2(MAX_ROW+1)-1:0]     i_n,
    input  wire logic [$clog2(MAX_ROW+1)-1:0]     i_rank_lo,
    input  wire logic [$clog2(MAX_ROW+1)-1:0]     i_rank_hi,
    output logic                                  o_re,
    output logic      [$clog2(MAX_ROW)-1:0]       o_raddr,
    input  wire logic [SAMPLE_BITS-1:0]           i_rdata,
    output logic                                  o_done,
    output logic      [SAMPLE_BITS-1:0]           o_key_lo,
    output logic      [SAMPLE_BITS-1:0]           o_key_hi
);
    localparam int CNT_W = $clog2(MAX_ROW + 1);
    localparam int AW    = $clog2(MAX_ROW);
    localparam int BW    = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

    nsq_pkg::t_sel_state r_state, n_state;
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_issue, n_issue;
    logic                   r_dv, r_dlast;
    logic [BW-1:0]          r_bit, n_bit;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_ka, n_ka, r_kb, n_kb;
    logic [CNT_W-1:0]       r_ca, n_ca, r_cb, n_cb;
    logic [SAMPLE_BITS-1:0] r_pa, n_pa, r_pb, n_pb;
    logic [SAMPLE_BITS-1:0] hi_mask;
    logic [AW-1:0]          last_addr;
    logic                   match_a, match_b, issue_last, done;

    assign last_addr  = AW'(r_n - CNT_W'(1));
    assign issue_last = (r_addr == last_addr);
    assign hi_mask    = ({SAMPLE_BITS{1'b1}} << r_bit) << 1;
    assign match_a    = (((i_rdata ^ r_pa) & hi_mask) == '0) && !i_rdata[r_bit];
    assign match_b    = (((i_rdata ^ r_pb) & hi_mask) == '0) && !i_rdata[r_bit];

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_issue = r_issue;
        n_bit   = r_bit;
        n_n     = r_n;
        n_ka    = r_ka;
        n_kb    = r_kb;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_pa    = r_pa;
        n_pb    = r_pb;
        done    = 1'b0;
        o_re    = 1'b0;
        case (r_state)
            nsq_pkg::SEL_IDLE: begin
                if (i_start) begin
                    n_state = nsq_pkg::SEL_RUN;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_bit   = BW'(SAMPLE_BITS - 1);
                    n_n     = i_n;
                    n_ka    = i_rank_lo;
                    n_kb    = i_rank_hi;
                    n_ca    = '0;
                    n_cb    = '0;
                    n_pa    = '0;
                    n_pb    = '0;
                end
            end
            nsq_pkg::SEL_RUN: begin
                o_re = r_issue;
                if (r_issue) begin
                    if (issue_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_dv) begin
                    if (match_a) begin
                        n_ca = r_ca + CNT_W'(1);
                    end
                    if (match_b) begin
                        n_cb = r_cb + CNT_W'(1);
                    end
                    if (r_dlast) begin
                        n_state = nsq_pkg::SEL_UPD;
                    end
                end
            end
            nsq_pkg::SEL_UPD: begin
                if (r_ka >= r_ca) begin
                    n_pa[r_bit] = 1'b1;
                    n_ka        = r_ka - r_ca;
                end
                if (r_kb >= r_cb) begin
                    n_pb[r_bit] = 1'b1;
                    n_kb        = r_kb - r_cb;
                end
                n_ca    = '0;
                n_cb    = '0;
                n_addr  = '0;
                if (r_bit == '0) begin
                    done    = 1'b1;
                    n_state = nsq_pkg::SEL_IDLE;
                end else begin
                    n_bit   = r_bit - BW'(1);
                    n_issue = 1'b1;
                    n_state = nsq_pkg::SEL_RUN;
                end
            end
            default: begin
                n_state = nsq_pkg::SEL_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsq_pkg::SEL_IDLE;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_dlast <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_dv    <= o_re;
            r_dlast <= o_re && issue_last;
            o_done  <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_bit  <= n_bit;
        r_n    <= n_n;
        r_ka   <= n_ka;
        r_kb   <= n_kb;
        r_ca   <= n_ca;
        r_cb   <= n_cb;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
    end

    assign o_raddr  = r_addr;
    assign o_key_lo = r_pa;
    assign o_key_hi = r_pb;
endmodule
`default_nettype wire

/* rtl/core/nan_skipping_quantile.sv */
// Top level: row loading, quantile position, selection control and interpolation.
// An input beat is taken in the cycle it is presented while a row loads.
// After the row-end beat the block takes no input until the result is out, a time set by
// one read pass of the row store per key bit over the n kept samples; an empty row skips selection.
// Reset is synchronous and active low; it clears the kept count and the flags and sets the register to 32768.
// The row store needs no clearing pass: only entries written in the current row are read.
`timescale 1ns / 1ps
`default_nettype none
module nan_skipping_quantile #(
    parameter int MAX_ROW     = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [16:0]            i_cfg_wdata,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_sample_is_nan,
    input  wire logic                   i_last_in_row,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [31:0]            o_quantile_value,
    output logic      [10:0]            o_valid_count,
    output logic                        o_row_empty,
    output logic                        o_row_overflow
);
    localparam int CNT_W = $clog2(MAX_ROW + 1);
    localparam int AW    = $clog2(MAX_ROW);
    localparam int PW    = 17 + CNT_W;
    localparam int MW    = SAMPLE_BITS + nsq_pkg::FRAC_BITS;
    localparam logic [SAMPLE_BITS-1:0] SIGN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    nsq_pkg::t_state r_state, n_state;
    logic [16:0]            r_q;
    logic [CNT_W-1:0]       r_kept, n_kept, r_n, n_n;
    logic                   r_drop, n_drop, r_rdrop, n_rdrop;
    logic [PW-1:0]          r_pos, n_pos;
    logic [MW-1:0]          r_prod, n_prod;
    logic                   r_ovalid, n_ovalid;
    logic [31:0]            r_oval, n_oval;
    logic [10:0]            r_ocnt, n_ocnt;
    logic                   r_oempty, n_oempty, r_oovf, n_oovf;
    logic                   in_fire, keep, mem_we, sel_start, sel_done, sel_re;
    logic [16:0]            q_sat;
    logic [CNT_W-1:0]       rank_lo, rank_hi;
    logic [CNT_W:0]         lo_p1;
    logic [AW-1:0]          sel_raddr;
    logic [SAMPLE_BITS-1:0] rdata, key_lo, key_hi, key_res;

    assign in_fire = i_in_valid && o_in_ready;
    assign keep    = !i_sample_is_nan && (r_kept < CNT_W'(MAX_ROW));
    assign mem_we  = in_fire && keep;
    assign q_sat   = (r_q > nsq_pkg::QFRAC_ONE) ? nsq_pkg::QFRAC_ONE : r_q;
    assign rank_lo = r_pos[nsq_pkg::FRAC_BITS +: CNT_W];
    assign lo_p1   = {1'b0, rank_lo} + (CNT_W+1)'(1);
    assign rank_hi = (lo_p1 < {1'b0, r_n}) ? lo_p1[CNT_W-1:0] : rank_lo;
    assign key_res = key_lo + r_prod[MW-1:nsq_pkg::FRAC_BITS];

    nsq_store #(.DEPTH(MAX_ROW), .WIDTH(SAMPLE_BITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_kept[AW-1:0]),
        .i_wdata (i_sample ^ SIGN),
        .i_re    (sel_re),
        .i_raddr (sel_raddr),
        .o_rdata (rdata)
    );

    nsq_select #(.MAX_ROW(MAX_ROW), .SAMPLE_BITS(SAMPLE_BITS)) u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sel_start),
        .i_n       (r_n),
        .i_rank_lo (rank_lo),
        .i_rank_hi (rank_hi),
        .o_re      (sel_re),
        .o_raddr   (sel_raddr),
        .i_rdata   (rdata),
        .o_done    (sel_done),
        .o_key_lo  (key_lo),
        .o_key_hi  (key_hi)
    );

    always_comb begin
        n_state    = r_state;
        n_kept     = r_kept;
        n_drop     = r_drop;
        n_n        = r_n;
        n_rdrop    = r_rdrop;
        n_pos      = r_pos;
        n_prod     = r_prod;
        n_oval     = r_oval;
        n_ocnt     = r_ocnt;
        n_oempty   = r_oempty;
        n_oovf     = r_oovf;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_in_ready = 1'b0;
        sel_start  = 1'b0;
        case (r_state)
            nsq_pkg::ST_LOAD: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    if (keep) begin
                        n_kept = r_kept + CNT_W'(1);
                    end else if (!i_sample_is_nan) begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in_row) begin
                        n_n     = n_kept;
                        n_rdrop = n_drop;
                        n_kept  = '0;
                        n_drop  = 1'b0;
                        n_state = (n_n == '0) ? nsq_pkg::ST_OUT : nsq_pkg::ST_POS;
                    end
                end
            end
            nsq_pkg::ST_POS: begin
                n_pos   = PW'(q_sat) * PW'(r_n - CNT_W'(1));
                n_state = nsq_pkg::ST_START;
            end
            nsq_pkg::ST_START: begin
                sel_start = 1'b1;
                n_state   = nsq_pkg::ST_SEL;
            end
            nsq_pkg::ST_SEL: begin
                if (sel_done) begin
                    n_state = nsq_pkg::ST_MUL;
                end
            end
            nsq_pkg::ST_MUL: begin
                n_prod  = MW'(key_hi - key_lo) * MW'(r_pos[nsq_pkg::FRAC_BITS-1:0]);
                n_state = nsq_pkg::ST_OUT;
            end
            nsq_pkg::ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_oval   = (r_n == '0) ? 32'd0 : 32'(key_res ^ SIGN);
                    n_ocnt   = 11'(r_n);
                    n_oempty = (r_n == '0);
                    n_oovf   = r_rdrop;
                    n_state  = nsq_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = nsq_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nsq_pkg::ST_LOAD;
            r_q      <= nsq_pkg::QFRAC_RESET;
            r_kept   <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kept   <= n_kept;
            r_drop   <= n_drop;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_q <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_rdrop  <= n_rdrop;
        r_pos    <= n_pos;
        r_prod   <= n_prod;
        r_oval   <= n_oval;
        r_ocnt   <= n_ocnt;
        r_oempty <= n_oempty;
        r_oovf   <= n_oovf;
    end

    assign o_out_valid      = r_ovalid;
    assign o_quantile_value = r_oval;
    assign o_valid_count    = r_ocnt;
    assign o_row_empty      = r_oempty;
    assign o_row_overflow   = r_oovf;
endmodule
`default_nettype wire

/* rtl/core/nsq_checker.sv */
// Port-level checker for the quantile block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "nan_skipping_quantile_macros.svh"
module nsq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_last_in_row,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_quantile_value,
    input wire logic [10:0] o_valid_count,
    input wire logic        o_row_empty
);
    `NSQ_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_quantile_value), "result beat changed while stalled")
    `NSQ_ASSERT(a_empty_zero, o_out_valid && o_row_empty |-> o_quantile_value == 32'd0 && o_valid_count == 11'd0, "empty row result not zero")
    `NSQ_ASSERT(a_count_nonzero, o_out_valid && !o_row_empty |-> o_valid_count != 11'd0, "non-empty row with zero count")
    `NSQ_ASSERT(a_busy_after_end, i_in_valid && o_in_ready && i_last_in_row |=> !o_in_ready, "beat taken right after row end")
endmodule

bind nan_skipping_quantile nsq_checker u_nsq_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the NaN-skipping quantile block.
`timescale 1ns / 1ps
module tb_top;
    localparam int DEPTH = 1024;
    localparam int SETTLE = 40;

    typedef struct {
        logic [31:0] value;
        logic [10:0] count;
        logic        empty;
        logic        ovf;
    } t_quant_res;

    typedef struct {
        logic [31:0] sample;
        logic        nan;
        logic        last;
        logic        chk;
        logic [31:0] value;
        logic [10:0] count;
        logic        empty;
        logic        ovf;
    } t_row_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_sample = '0;
    logic        i_sample_is_nan = 1'b0;
    logic        i_last_in_row = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_quantile_value;
    logic [10:0] o_valid_count;
    logic        o_row_empty;
    logic        o_row_overflow;

    logic [31:0] row_keys[$];
    logic        row_dropped = 1'b0;
    logic [16:0] q_frac = nsq_pkg::QFRAC_RESET;
    t_quant_res  expected_q[$];
    t_row_beat   typed_q[$];
    int          n_errors = 0;
    int          out_gap = 0;

    nan_skipping_quantile #(.MAX_ROW(DEPTH), .SAMPLE_BITS(32)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("** nan_skipping_quantile: FAILED **");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp);
        n_errors++;
    endtask

    function automatic t_quant_res predict_quantile();
        t_quant_res r;
        logic [31:0] s[];
        logic [31:0] t;
        logic [33:0] pos;
        logic [32:0] diff;
        logic [48:0] add;
        longint unsigned q, lo, frac;
        int n;
        n = row_keys.size();
        r.count = n[10:0];
        r.empty = (n == 0);
        r.ovf = row_dropped;
        r.value = '0;
        if (n > 0) begin
            s = new[n];
            foreach (row_keys[i]) s[i] = row_keys[i];
            for (int i = 1; i < n; i++) begin
                t = s[i];
                for (int j = i - 1; j >= 0 && $signed(s[j]) > $signed(t); j--) begin
                    s[j + 1] = s[j];
                    s[j] = t;
                end
            end
            q = (q_frac > nsq_pkg::QFRAC_ONE) ? 65536 : q_frac;
            pos = q * (n - 1);
            lo = pos >> 16;
            frac = pos & 16'hFFFF;
            if (lo >= n) lo = n - 1;
            if (lo + 1 >= n) begin
                r.value = s[lo];
            end else begin
                diff = {1'b0, s[lo + 1] ^ 32'h80000000} - {1'b0, s[lo] ^ 32'h80000000};
                add = (diff[31:16] * frac) + ((diff[15:0] * frac) >> 16);
                r.value = s[lo] + add[31:0];
            end
        end
        row_keys.delete();
        row_dropped = 1'b0;
        return r;
    endfunction

    task automatic send_beat(input logic [31:0] smp, input logic nan, input logic last);
        t_quant_res r;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= smp;
        i_sample_is_nan <= nan;
        i_last_in_row <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (!nan) begin
            if (row_keys.size() < DEPTH) row_keys = {row_keys, smp};
            else row_dropped = 1'b1;
        end
        if (last) begin
            r = predict_quantile();
            expected_q = {expected_q, r};
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_qfrac(input logic [16:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        q_frac = v;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_row(input int len, input int nan_pct);
        for (int i = 0; i < len; i++)
            send_beat(rand_sample(), $urandom_range(0, 99) < nan_pct, i == len - 1);
    endtask

    always @(posedge i_clk) begin
        t_quant_res e;
        t_row_beat  d;
        int         g;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected beat", o_quantile_value, 0);
            end else begin
                e = expected_q.pop_front();
                if (typed_q.size() != 0) begin
                    d = typed_q.pop_front();
                    if (d.chk) begin
                        e.value = d.value;
                        e.count = d.count;
                        e.empty = d.empty;
                        e.ovf = d.ovf;
                    end
                end
                if (o_quantile_value !== e.value) report("value", o_quantile_value, e.value);
                if (o_valid_count !== e.count) report("count", o_valid_count, e.count);
                if (o_row_empty !== e.empty) report("empty", o_row_empty, e.empty);
                if (o_row_overflow !== e.ovf) report("overflow", o_row_overflow, e.ovf);
            end
        end
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            g = $urandom_range(0, 3);
            out_gap <= (g > 0) ? g - 1 : 0;
            i_out_ready <= (g == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    t_row_beat directed[] = '{
        '{32'h0, 1'b1, 1'b1, 1'b1, 32'h0, 11'd0, 1'b1, 1'b0},
        '{32'h7FFFFFFF, 1'b0, 1'b1, 1'b1, 32'h7FFFFFFF, 11'd1, 1'b0, 1'b0},
        '{32'h80000000, 1'b0, 1'b1, 1'b1, 32'h80000000, 11'd1, 1'b0, 1'b0},
        '{32'h00010000, 1'b0, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h12345678, 1'b1, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h00030000, 1'b0, 1'b1, 1'b1, 32'h00020000, 11'd2, 1'b0, 1'b0},
        '{32'h80000000, 1'b0, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h7FFFFFFF, 1'b0, 1'b1, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h00000001, 1'b0, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h00000005, 1'b0, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'hAAAA5555, 1'b1, 1'b1, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'h55555555, 1'b1, 1'b0, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0},
        '{32'hFFFF0000, 1'b0, 1'b1, 1'b0, 32'h0, 11'd0, 1'b0, 1'b0}
    };

    initial begin
        t_row_beat b;
        logic [16:0] q_set[] = '{17'd0, nsq_pkg::QFRAC_ONE, 17'h1FFFF, 17'd1, 17'd16384,
                                 17'd65535};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[i]) begin
            b = directed[i];
            if (b.last) typed_q = {typed_q, b};
            send_beat(b.sample, b.nan, b.last);
        end
        wait_drained();
        foreach (q_set[k]) begin
            write_qfrac(q_set[k]);
            repeat (2) send_row($urandom_range(1, 5), 20);
            send_row(1, 100);
            wait_drained();
        end
        write_qfrac(nsq_pkg::QFRAC_RESET);
        send_row(DEPTH + 1, 0);
        wait_drained();
        write_qfrac(17'($urandom_range(0, 65536)));
        for (int r = 0; r < 8; r++) begin
            if (r == 4) wait_drained();
            send_row($urandom_range(1, 6), $urandom_range(0, 40));
        end
        wait_drained();
        if (n_errors == 0) begin
            $display("** nan_skipping_quantile: PASSED **");
        end else begin
            $display("** nan_skipping_quantile: FAILED **");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/nsq_pkg.sv
rtl/core/nsq_store.sv
rtl/core/nsq_select.sv
rtl/core/nan_skipping_quantile.sv
rtl/core/nsq_checker.sv
dv/tb_top.sv
